// File: rtl/pfbs_pkg.sv
package pfbs_pkg;

	localparam int COLUMNS     = 84;
	localparam int PAGES       = 6;
	localparam int STORE_BYTES = COLUMNS * PAGES;

	localparam int TYPE_W = 3;
	localparam int PAGE_W = 3;
	localparam int COL_W  = 7;
	localparam int Y_W    = 6;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = $clog2(STORE_BYTES);

	typedef logic [TYPE_W-1:0] req_type_t;
	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [Y_W-1:0]    ypos_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam req_type_t REQ_CLEAR = 3'd0;
	localparam req_type_t REQ_OR    = 3'd1;
	localparam req_type_t REQ_SHL   = 3'd2;
	localparam req_type_t REQ_SHR   = 3'd3;
	localparam req_type_t REQ_READ  = 3'd4;

	localparam col_t  LAST_COL   = COL_W'(COLUMNS - 1);
	localparam page_t LAST_PAGE  = PAGE_W'(PAGES - 1);
	localparam addr_t ROW_STRIDE = ADDR_W'(COLUMNS);
	localparam addr_t LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);

endpackage

// File: rtl/pfbs_if.sv
interface pfbs_req_if;
	import pfbs_pkg::*;

	logic      valid;
	logic      ready;
	req_type_t req_type;
	page_t     page_row;
	col_t      column;
	ypos_t     y_position;
	byte_t     pixel_byte;
	col_t      end_column;

	modport source (output valid, req_type, page_row, column, y_position, pixel_byte,
		end_column, input ready);
	modport sink (input valid, req_type, page_row, column, y_position, pixel_byte,
		end_column, output ready);
endinterface

interface pfbs_rsp_if;
	import pfbs_pkg::*;

	logic      valid;
	logic      ready;
	byte_t     read_data;
	req_type_t done_type;

	modport source (output valid, read_data, done_type, input ready);
	modport sink (input valid, read_data, done_type, output ready);
endinterface

// File: rtl/page_framebuffer_blit_shift_unit.sv
// channel | dir | fields
// req     | in  | req_type page_row column y_position pixel_byte end_column
// rsp     | out | read_data done_type
//
// Steps: clear writes every byte; OR-in reads then writes one byte, or two when the y
// offset is nonzero and a page lies below; read waits on the registered read port; shift
// copies clamped end_column bytes, then zeroes the vacated column, skipping all when that
// is zero or the page is out of range. The store has one write port and a registered read.
// Reset: a clearing pass writes zero to all 504 bytes; req.ready stays low for it.
// Stalls: one item at a time; a new request is taken while a result waits on rsp,
// and the next result then holds until that transfer.
module page_framebuffer_blit_shift_unit (
	input  logic              clk,
	input  logic              arst_n,
	pfbs_req_if.sink          req,
	pfbs_rsp_if.source        rsp
);
	import pfbs_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CLR      = 4'd1;
	localparam logic [3:0] S_OR_RD    = 4'd2;
	localparam logic [3:0] S_OR_WR1   = 4'd3;
	localparam logic [3:0] S_OR_WR2   = 4'd4;
	localparam logic [3:0] S_RD       = 4'd5;
	localparam logic [3:0] S_RD_WAIT  = 4'd6;
	localparam logic [3:0] S_SH_RUN   = 4'd7;
	localparam logic [3:0] S_SH_DRAIN = 4'd8;
	localparam logic [3:0] S_SH_ZERO  = 4'd9;
	localparam logic [3:0] S_DONE     = 4'd10;

	byte_t mem [STORE_BYTES];

	logic [3:0] state_q;
	req_type_t  op_q;
	addr_t      base_q;
	col_t       col_q;
	col_t       src_q;
	col_t       cnt_q;
	col_t       zcol_q;
	addr_t      or_addr_q;
	byte_t      lo_q;
	byte_t      hi_q;
	logic       two_q;
	logic       clr_resp_q;
	addr_t      clr_q;
	byte_t      res_q;
	byte_t      rdata_q;
	logic       pend_s1;
	addr_t      pdst_s1;
	logic       out_valid_q;
	byte_t      out_data_q;
	req_type_t  out_type_q;

	col_t       e_clamp;
	page_t      pg_sel;
	addr_t      base_d;
	col_t       col_sel;
	addr_t      row_addr;
	addr_t      raddr;
	logic       we;
	addr_t      waddr;
	byte_t      wdata;
	logic [2*BYTE_W-1:0] blit_w;
	logic       accept;

	assign accept  = req.valid && req.ready;
	assign e_clamp = (req.end_column > LAST_COL) ? LAST_COL : req.end_column;
	assign pg_sel  = (req.req_type == REQ_OR) ? page_t'(req.y_position[Y_W-1:3]) : req.page_row;
	assign base_d  = ADDR_W'(ADDR_W'(pg_sel) * ROW_STRIDE);
	assign blit_w  = {{BYTE_W{1'b0}}, req.pixel_byte} << req.y_position[2:0];

	always_comb begin
		unique case (state_q)
			S_SH_RUN:  col_sel = src_q;
			S_SH_ZERO: col_sel = zcol_q;
			default:   col_sel = col_q;
		endcase
	end

	assign row_addr = base_q + ADDR_W'(col_sel);
	assign raddr    = (state_q == S_OR_WR1) ? or_addr_q + ROW_STRIDE : row_addr;

	always_comb begin
		we    = 1'b0;
		waddr = row_addr;
		wdata = '0;
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (pend_s1) begin
			we    = 1'b1;
			waddr = pdst_s1;
			wdata = rdata_q;
		end else if (state_q == S_OR_WR1) begin
			we    = 1'b1;
			waddr = or_addr_q;
			wdata = rdata_q | lo_q;
		end else if (state_q == S_OR_WR2) begin
			we    = 1'b1;
			waddr = or_addr_q + ROW_STRIDE;
			wdata = rdata_q | hi_q;
		end else if (state_q == S_SH_ZERO) begin
			we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.done_type = out_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_resp_q  <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SH_RUN);
			if (rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= req.req_type;
						base_q <= base_d;
						col_q  <= req.column;
						lo_q   <= blit_w[BYTE_W-1:0];
						hi_q   <= blit_w[2*BYTE_W-1:BYTE_W];
						two_q  <= (req.y_position[2:0] != '0) &&
							(page_t'(req.y_position[Y_W-1:3]) < LAST_PAGE);
						cnt_q  <= e_clamp;
						res_q  <= '0;
						if (req.req_type == REQ_SHL) begin
							src_q  <= COL_W'(1);
							zcol_q <= e_clamp;
						end else begin
							src_q  <= e_clamp - COL_W'(1);
							zcol_q <= '0;
						end
						case (req.req_type) inside
							REQ_CLEAR: begin
								clr_q      <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= S_CLR;
							end
							REQ_OR: begin
								if (req.column <= LAST_COL &&
									page_t'(req.y_position[Y_W-1:3]) <= LAST_PAGE) begin
									state_q <= S_OR_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							REQ_SHL, REQ_SHR: begin
								if (req.page_row <= LAST_PAGE && e_clamp != '0) begin
									state_q <= S_SH_RUN;
								end else begin
									state_q <= S_DONE;
								end
							end
							REQ_READ: begin
								if (req.page_row <= LAST_PAGE && req.column <= LAST_COL) begin
									state_q <= S_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= clr_resp_q ? S_DONE : S_IDLE;
					end
				end
				S_OR_RD: begin
					or_addr_q <= row_addr;
					state_q   <= S_OR_WR1;
				end
				S_OR_WR1: begin
					state_q <= two_q ? S_OR_WR2 : S_DONE;
				end
				S_OR_WR2: begin
					state_q <= S_DONE;
				end
				S_RD: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					res_q   <= rdata_q;
					state_q <= S_DONE;
				end
				S_SH_RUN: begin
					pdst_s1 <= (op_q == REQ_SHL) ? row_addr - ADDR_W'(1) : row_addr + ADDR_W'(1);
					src_q   <= (op_q == REQ_SHL) ? src_q + COL_W'(1) : src_q - COL_W'(1);
					cnt_q   <= cnt_q - COL_W'(1);
					if (cnt_q == COL_W'(1)) begin
						state_q <= S_SH_DRAIN;
					end
				end
				S_SH_DRAIN: begin
					state_q <= S_SH_ZERO;
				end
				S_SH_ZERO: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						out_type_q  <= op_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> waddr <= LAST_ADDR)
		else $error("frame store write beyond last byte");

	a_pend_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_SH_RUN || state_q == S_SH_DRAIN))
		else $error("shift copy pending outside a shift");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside completion");
`endif

endmodule
